// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: src/jkve_pkg.sv
package jkve_pkg;

  // Window and text geometry
  localparam int WINDOW_DEPTH = 10;
  localparam int KEY_TOTAL    = 3;
  localparam int TEXT_SLOTS   = 7;
  localparam int BYTE_W       = 8;
  localparam int TEXT_W       = TEXT_SLOTS * BYTE_W;
  localparam int LEN_W        = 3;
  localparam int IDX_W        = 2;
  localparam int LEFT_W       = 2;

  // Defaults for the top-level parameters
  localparam int VALUE_CHARS_DEF = 7;
  localparam int FIELD_COUNT_DEF = 3;

  localparam logic [LEFT_W-1:0] FIELDS_RESET = 2'd3;

  // Characters with a meaning inside a capture
  localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CHAR_BRACE = 8'h7D;
  localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;

  typedef logic [BYTE_W-1:0] key_row_t [WINDOW_DEPTH];

  // Keys right-aligned in the window; index 9 is the newest byte
  localparam key_row_t KEY_TEXT [KEY_TOTAL] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, CHAR_QUOTE, "t", "e", "m", "p", CHAR_QUOTE},
    '{CHAR_QUOTE, "p", "r", "e", "s", "s", "u", "r", "e", CHAR_QUOTE},
    '{CHAR_QUOTE, "h", "u", "m", "i", "d", "i", "t", "y", CHAR_QUOTE}
  };

  // Window positions that take part in each key compare
  localparam logic [WINDOW_DEPTH-1:0] KEY_CARE [KEY_TOTAL] = '{
    10'b11_1111_0000,
    10'b11_1111_1111,
    10'b11_1111_1111
  };

  typedef struct packed {
    logic [IDX_W-1:0]  field_index;
    logic [TEXT_W-1:0] value_text;
    logic [LEN_W-1:0]  value_length;
    logic              truncated;
    logic              all_found;
  } result_t;

  typedef struct packed {
    logic    emit;
    logic    stopped;
    result_t res;
  } cap_status_t;

endpackage

// File: src/jkve_byte_cell.sv
module jkve_byte_cell #(
  parameter int POS = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic [jkve_pkg::BYTE_W-1:0]   din,
  output logic [jkve_pkg::BYTE_W-1:0]   q,
  output logic [jkve_pkg::KEY_TOTAL-1:0] hit
);

  // Compare the byte arriving in this slot against each key's character
  always_comb begin
    for (int k = 0; k < jkve_pkg::KEY_TOTAL; k++) begin
      hit[k] = !jkve_pkg::KEY_CARE[k][POS] || (din == jkve_pkg::KEY_TEXT[k][POS]);
    end
  end

  // Hold the byte; take din (the neighbour's byte, or the new byte in the last cell) on each shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= din;
    end
  end

endmodule

// File: src/jkve_capture.sv
module jkve_capture #(
  parameter int VALUE_CHARS = jkve_pkg::VALUE_CHARS_DEF,
  parameter int FIELD_COUNT = jkve_pkg::FIELD_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [jkve_pkg::LEFT_W-1:0]    cfg_wr_data,
  input  logic                           step,
  input  logic [jkve_pkg::BYTE_W-1:0]    rx_byte,
  input  logic [jkve_pkg::KEY_TOTAL-1:0] key_match,
  output jkve_pkg::cap_status_t          status
);

  localparam int CAP_INT = (VALUE_CHARS < jkve_pkg::TEXT_SLOTS) ?
                           VALUE_CHARS : jkve_pkg::TEXT_SLOTS;
  localparam logic [jkve_pkg::LEN_W-1:0] CAP = jkve_pkg::LEN_W'(CAP_INT);

  logic                          active, active_next;
  logic [jkve_pkg::IDX_W-1:0]    idx, idx_next;
  logic [jkve_pkg::TEXT_W-1:0]   text, text_next;
  logic [jkve_pkg::LEN_W-1:0]    cnt, cnt_next;
  logic                          ovf, ovf_next;
  logic [jkve_pkg::LEFT_W-1:0]   left, left_next;

  logic                          any_match;
  logic [jkve_pkg::IDX_W-1:0]    match_idx;
  logic                          term;
  logic                          keep;
  logic                          emit;

  // Pick the watched key that matched; the last one in order wins
  always_comb begin
    any_match = 1'b0;
    match_idx = '0;
    for (int f = 0; f < jkve_pkg::KEY_TOTAL; f++) begin
      if (f < FIELD_COUNT && key_match[f]) begin
        any_match = 1'b1;
        match_idx = jkve_pkg::IDX_W'(f);
      end
    end
  end

  assign term = (rx_byte == jkve_pkg::CHAR_COMMA) || (rx_byte == jkve_pkg::CHAR_BRACE);
  assign keep = (rx_byte != jkve_pkg::CHAR_COLON) && (rx_byte != jkve_pkg::CHAR_QUOTE);

  // Load the field count on a config write; else open, fill and close the single live capture
  always_comb begin
    active_next = active;
    idx_next    = idx;
    text_next   = text;
    cnt_next    = cnt;
    ovf_next    = ovf;
    left_next   = left;
    emit        = 1'b0;
    if (cfg_wr_en) begin
      left_next = cfg_wr_data;
    end else if (step && left != '0) begin
      if (any_match) begin
        active_next = 1'b1;
        idx_next    = match_idx;
        text_next   = '0;
        cnt_next    = '0;
        ovf_next    = 1'b0;
      end else if (active) begin
        if (term) begin
          emit        = 1'b1;
          active_next = 1'b0;
          left_next   = left - 1'b1;
        end else if (keep) begin
          if (cnt < CAP) begin
            text_next[{cnt, 3'b000} +: jkve_pkg::BYTE_W] = rx_byte;
            cnt_next = cnt + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
      end
    end
  end

  assign status.emit             = emit;
  assign status.stopped          = (left == '0);
  assign status.res.field_index  = idx;
  assign status.res.value_text   = text;
  assign status.res.value_length = cnt;
  assign status.res.truncated    = ovf;
  assign status.res.all_found    = (left == jkve_pkg::LEFT_W'(1));

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      left   <= jkve_pkg::FIELDS_RESET;
      cnt    <= '0;
      ovf    <= 1'b0;
      text   <= '0;
      idx    <= '0;
    end else begin
      active <= active_next;
      left   <= left_next;
      cnt    <= cnt_next;
      ovf    <= ovf_next;
      text   <= text_next;
      idx    <= idx_next;
    end
  end

endmodule

// File: src/json_key_value_extractor.sv
// Picks the values of the quoted keys "temp", "pressure" and "humidity" out of
// a byte stream of JSON text. One byte enters per cycle on the slave side and
// is accepted whenever the output register is empty or being drained, so the
// sustained rate is one byte per clock unless the master side stalls; the key
// compare on the ten-cell window's inputs is combinational. A result word is
// registered from the comma or closing brace that ends a value and appears in
// the cycle after it: tdata carries the text (first character in the lowest
// byte) and its length, tuser the field index and a truncation flag, and tlast
// marks the completion that reaches the configured field count. Then bytes
// are still accepted but dropped until reset or a new write of the field count.
module json_key_value_extractor #(
  parameter int VALUE_CHARS = jkve_pkg::VALUE_CHARS_DEF,
  parameter int FIELD_COUNT = jkve_pkg::FIELD_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,     // fields_to_find
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // [55:0] value_text, [58:56] value_length, rest zero
  output logic [2:0]  m_axis_tuser,    // [1:0] field_index, [2] truncated
  output logic        m_axis_tlast     // all_found
);

  logic                          step;
  logic                          shift;
  logic [jkve_pkg::BYTE_W-1:0]   win_q   [jkve_pkg::WINDOW_DEPTH];
  logic [jkve_pkg::BYTE_W-1:0]   win_d   [jkve_pkg::WINDOW_DEPTH];
  logic [jkve_pkg::KEY_TOTAL-1:0] win_hit [jkve_pkg::WINDOW_DEPTH];
  logic [jkve_pkg::KEY_TOTAL-1:0] key_match;
  jkve_pkg::cap_status_t         status;
  jkve_pkg::result_t             out_res;
  logic                          out_valid;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign shift         = step && !status.stopped;

  // Byte window: newest byte enters the last cell, older ones move down
  for (genvar i = 0; i < jkve_pkg::WINDOW_DEPTH; i++) begin : g_cell
    if (i == jkve_pkg::WINDOW_DEPTH - 1) begin : g_head
      assign win_d[i] = s_axis_tdata;
    end else begin : g_body
      assign win_d[i] = win_q[i+1];
    end
    jkve_byte_cell #(.POS(i)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   (win_d[i]),
      .q     (win_q[i]),
      .hit   (win_hit[i])
    );
  end

  // A key matches when every cell agrees
  always_comb begin
    key_match = '1;
    for (int i = 0; i < jkve_pkg::WINDOW_DEPTH; i++) begin
      key_match = key_match & win_hit[i];
    end
  end

  jkve_capture #(
    .VALUE_CHARS (VALUE_CHARS),
    .FIELD_COUNT (FIELD_COUNT)
  ) u_capture (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .rx_byte     (s_axis_tdata),
    .key_match   (key_match),
    .status      (status)
  );

  // Output register: load on a completion, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && status.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && status.emit) begin
      out_res <= status.res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'b0, out_res.value_length, out_res.value_text};
  assign m_axis_tuser  = {out_res.truncated, out_res.field_index};
  assign m_axis_tlast  = out_res.all_found;

endmodule

// File: src/jkve_checker.sv
`include "assert_macros.svh"

module jkve_checker #(
  parameter int VALUE_CHARS = jkve_pkg::VALUE_CHARS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  localparam int CAP_INT = (VALUE_CHARS < jkve_pkg::TEXT_SLOTS) ?
                           VALUE_CHARS : jkve_pkg::TEXT_SLOTS;
  localparam logic [2:0] CAP = 3'(CAP_INT);

  // Hold a stalled word
  `ASSERT_NEXT(a_stall_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Take bytes whenever the output register is empty
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)
  // Stop producing once the final field has gone out
  `ASSERT_NEXT(a_quiet_after_last, clk, rst, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
  // Truncation only happens with a full value
  `ASSERT_IMPLY(a_trunc_full, clk, rst, m_axis_tvalid && m_axis_tuser[2], m_axis_tdata[58:56] == CAP)

endmodule

bind json_key_value_extractor jkve_checker #(.VALUE_CHARS(VALUE_CHARS)) u_jkve_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
